/* sv/lidar_narrow_object_finder_macros.svh */
// Assertion helpers used by the checker file.
`ifndef LIDAR_NARROW_OBJECT_FINDER_MACROS_SVH
`define LIDAR_NARROW_OBJECT_FINDER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define LNOF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define LNOF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lnof_pkg.sv */
package lnof_pkg;

	localparam int SCAN_BINS = 180;
	localparam int BIN_W     = $clog2(SCAN_BINS);

	localparam int RANGE_W   = 14;
	localparam int BINIDX_W  = 8;
	localparam int RUN_W     = 4;
	localparam int RLEN_W    = 5;
	localparam int ANGLE_W   = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 14;

	localparam logic [RLEN_W-1:0] RLEN_MAX = '1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTINUITY_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN          = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN          = 2'd3;

	localparam logic [RANGE_W-1:0] JUMP_THRESHOLD_RST   = 14'd300;
	localparam logic [RANGE_W-1:0] CONTINUITY_LIMIT_RST = 14'd100;
	localparam logic [RUN_W-1:0]   MIN_RUN_RST          = 4'd2;
	localparam logic [RUN_W-1:0]   MAX_RUN_RST          = 4'd10;

	typedef struct packed {
		logic [RANGE_W-1:0]  range_mm;
		logic [BINIDX_W-1:0] bin_index;
		logic                scan_first;
		logic                scan_last;
	} sample_t;

	typedef struct packed {
		logic               found;
		logic [ANGLE_W-1:0] angle_deg;
	} result_t;

	typedef struct packed {
		logic [RANGE_W-1:0] jump_threshold;
		logic [RANGE_W-1:0] continuity_limit;
		logic [RUN_W-1:0]   min_run;
		logic [RUN_W-1:0]   max_run;
	} cfg_t;

	typedef struct packed {
		logic [RANGE_W-1:0]  prev_range;
		logic [BINIDX_W-1:0] prev_bin;
		logic                have_prev;
		logic                seeking_edge;
		logic [RLEN_W-1:0]   run_length;
		logic [RANGE_W-1:0]  run_start_range;
		logic                finished;
	} track_t;

	// bin index reduced modulo SCAN_BINS, one entry per 8-bit code
	typedef logic [(1 << BINIDX_W)-1:0][BIN_W-1:0] bin_lut_t;

	function automatic bin_lut_t build_bin_lut();
		bin_lut_t lut;
		for (int i = 0; i < (1 << BINIDX_W); i++) begin
			lut[i] = BIN_W'(i % SCAN_BINS);
		end
		return lut;
	endfunction

	localparam bin_lut_t BIN_MOD_LUT = build_bin_lut();

endpackage

/* sv/lnof_pair_eval.sv */
module lnof_pair_eval (
	input  lnof_pkg::track_t  cur,
	input  lnof_pkg::cfg_t    cfg,
	input  lnof_pkg::sample_t smp,
	output lnof_pkg::track_t  nxt,
	output logic              res_valid,
	output lnof_pkg::result_t res
);

	lnof_pkg::track_t                st0;
	logic                            examine;
	logic                            over;
	logic                            seek1;
	logic [lnof_pkg::RLEN_W-1:0]     rl1;
	logic                            near_edge;
	logic                            far_edge;
	logic                            contig;
	logic [lnof_pkg::RANGE_W-1:0]    start_diff;
	logic                            hit;
	logic                            fin_after;
	logic [lnof_pkg::BIN_W-1:0]      bin_mod;
	logic [lnof_pkg::BIN_W:0]        centre_sum;
	logic [lnof_pkg::BIN_W-1:0]      centre;
	logic [lnof_pkg::ANGLE_W-1:0]    angle;

	// window start clears the search before the sample is used
	always_comb begin
		st0 = cur;
		if (smp.scan_first) begin
			st0.have_prev    = 1'b0;
			st0.finished     = 1'b0;
			st0.seeking_edge = 1'b1;
			st0.run_length   = lnof_pkg::RLEN_W'(1);
		end
	end

	assign examine = st0.have_prev && !st0.finished;
	assign over    = st0.run_length > {1'b0, cfg.max_run};
	assign seek1   = st0.seeking_edge || over;
	assign rl1     = over ? lnof_pkg::RLEN_W'(1) : st0.run_length;

	assign near_edge = (st0.prev_range > smp.range_mm) &&
		((st0.prev_range - smp.range_mm) > cfg.jump_threshold);
	assign far_edge  = (smp.range_mm > st0.prev_range) &&
		((smp.range_mm - st0.prev_range) > cfg.jump_threshold);
	assign start_diff = (st0.run_start_range > smp.range_mm) ?
		(st0.run_start_range - smp.range_mm) : (smp.range_mm - st0.run_start_range);
	assign contig = start_diff < cfg.continuity_limit;

	// centre bin: previous bin minus half the run, wrapped onto the scan
	assign bin_mod    = lnof_pkg::BIN_MOD_LUT[st0.prev_bin];
	assign centre_sum = {1'b0, bin_mod} + (lnof_pkg::BIN_W+1)'(lnof_pkg::SCAN_BINS)
		- (lnof_pkg::BIN_W+1)'(rl1[lnof_pkg::RLEN_W-1:1]);
	assign centre = (centre_sum >= (lnof_pkg::BIN_W+1)'(lnof_pkg::SCAN_BINS)) ?
		lnof_pkg::BIN_W'(centre_sum - (lnof_pkg::BIN_W+1)'(lnof_pkg::SCAN_BINS)) :
		centre_sum[lnof_pkg::BIN_W-1:0];
	assign angle = lnof_pkg::ANGLE_W'({centre, 1'b0});

	always_comb begin
		nxt = st0;
		hit = 1'b0;
		if (examine) begin
			nxt.run_length = rl1;
			if (seek1) begin
				nxt.seeking_edge = !near_edge;
				if (near_edge) begin
					nxt.run_start_range = smp.range_mm;
				end
			end else if (contig) begin
				if (rl1 != lnof_pkg::RLEN_MAX) begin
					nxt.run_length = rl1 + lnof_pkg::RLEN_W'(1);
				end
			end else if (far_edge) begin
				hit              = rl1 >= {1'b0, cfg.min_run};
				nxt.seeking_edge = 1'b1;
				nxt.run_length   = lnof_pkg::RLEN_W'(1);
			end else begin
				// continuity broken: restart and look at the same pair for a near edge
				nxt.seeking_edge = !near_edge;
				nxt.run_length   = lnof_pkg::RLEN_W'(1);
				if (near_edge) begin
					nxt.run_start_range = smp.range_mm;
				end
			end
		end

		fin_after    = st0.finished || hit;
		nxt.finished = fin_after;
		if (smp.scan_last) begin
			nxt.finished     = 1'b1;
			nxt.seeking_edge = 1'b1;
			nxt.run_length   = lnof_pkg::RLEN_W'(1);
		end

		nxt.prev_range = smp.range_mm;
		nxt.prev_bin   = smp.bin_index;
		nxt.have_prev  = 1'b1;

		res_valid     = hit || (smp.scan_last && !fin_after);
		res.found     = hit;
		res.angle_deg = hit ? angle : '0;
	end

endmodule

/* sv/lidar_narrow_object_finder.sv */
// Narrow object finder for one lidar scan window.
//
// Sample channel: sample_valid / sample_stall carry one range sample per
// transaction (range, angle bin, first and last marks) in angle order.
// Result channel: result_valid / result_stall carry at most one transaction
// per window: found with the centre angle, or not-found on the last sample.
// Configuration: cfg_we writes cfg_data into the register cfg_index on the
// clock edge; write only while the block is idle.
//
// Path: a taken sample waits in the input register, where it is judged; its
// result, if any, then enters the output register.
// Throughput: one sample per cycle while the input register is not stalled;
// the pair check and the run counter are combinational between the two registers.
// When the receiver stalls, the held result stays put; one more sample is
// parked in the input register and is stalled only if it also has a result
// to deliver. Samples with no result keep flowing.
// Reset (arst_n low): state registers return to their defaults, the search waits
// for a near edge and both channels come up empty.
module lidar_narrow_object_finder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  lnof_pkg::sample_t              sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output lnof_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [lnof_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lnof_pkg::CFG_W-1:0]     cfg_data
);

	lnof_pkg::cfg_t    cfg_q;
	lnof_pkg::track_t  track_q;
	lnof_pkg::track_t  track_nxt;
	lnof_pkg::sample_t sample_s1;
	logic              valid_s1;
	lnof_pkg::result_t result_q;
	logic              result_valid_q;
	logic              eval_res_valid;
	lnof_pkg::result_t eval_res;
	logic              out_free;
	logic              process;
	logic              take_in;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jump_threshold   <= lnof_pkg::JUMP_THRESHOLD_RST;
			cfg_q.continuity_limit <= lnof_pkg::CONTINUITY_LIMIT_RST;
			cfg_q.min_run          <= lnof_pkg::MIN_RUN_RST;
			cfg_q.max_run          <= lnof_pkg::MAX_RUN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lnof_pkg::REG_JUMP_THRESHOLD:   cfg_q.jump_threshold   <= cfg_data;
				lnof_pkg::REG_CONTINUITY_LIMIT: cfg_q.continuity_limit <= cfg_data;
				lnof_pkg::REG_MIN_RUN: cfg_q.min_run <= cfg_data[lnof_pkg::RUN_W-1:0];
				lnof_pkg::REG_MAX_RUN: cfg_q.max_run <= cfg_data[lnof_pkg::RUN_W-1:0];
			endcase
		end
	end

	// Pair check on the registered sample against the tracked state.
	lnof_pair_eval u_eval (
		.cur       (track_q),
		.cfg       (cfg_q),
		.smp       (sample_s1),
		.nxt       (track_nxt),
		.res_valid (eval_res_valid),
		.res       (eval_res)
	);

	// Advance the held sample unless it has a result and the output slot is blocked.
	assign out_free     = !result_valid_q || !result_stall;
	assign process      = valid_s1 && (!eval_res_valid || out_free);
	assign sample_stall = valid_s1 && !process;
	assign take_in      = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1 <= sample;
		end
	end

	// Tracked search state: default is seeking a near edge with a run of one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q.prev_range      <= '0;
			track_q.prev_bin        <= '0;
			track_q.have_prev       <= 1'b0;
			track_q.seeking_edge    <= 1'b1;
			track_q.run_length      <= lnof_pkg::RLEN_W'(1);
			track_q.run_start_range <= '0;
			track_q.finished        <= 1'b0;
		end else if (process) begin
			track_q <= track_nxt;
		end
	end

	// Output register: load a new result, drop the old one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (process && eval_res_valid) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && eval_res_valid) begin
			result_q <= eval_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* sv/lnof_checker.sv */
`include "lidar_narrow_object_finder_macros.svh"

module lnof_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input lnof_pkg::result_t result
);

	`LNOF_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
	`LNOF_ASSERT_NOW(a_notfound_zero, result_valid && !result.found, result.angle_deg == '0, "not-found result carries an angle")
	`LNOF_ASSERT_NOW(a_angle_even, result_valid, result.angle_deg[0] == 1'b0, "angle is not a whole bin")

endmodule

bind lidar_narrow_object_finder lnof_checker u_lnof_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
